[sv/selt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the shared/exclusive lock table.
// No dependencies; imported by shared_exclusive_lock_table, lock_table_checker and tb.

package selt_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 48;
   localparam int STATUS_W = 3;
   localparam int VALUE_W  = 9;

   localparam logic signed [VALUE_W-1:0] LOCK_FREE  = '0;
   localparam logic signed [VALUE_W-1:0] LOCK_ONE   = VALUE_W'(1);
   localparam logic signed [VALUE_W-1:0] LOCK_EXCL  = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_SHARED  = 2'd0,
      CMD_EXCL    = 2'd1,
      CMD_UNLOCK  = 2'd2,
      CMD_UPGRADE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED  = 3'd0,
      ST_XHELD    = 3'd1,
      ST_OTHERS   = 3'd2,
      ST_NOSHARED = 3'd3,
      ST_FULL     = 3'd4,
      ST_NOTHELD  = 3'd5
   } status_type;

endpackage

[sv/shared_exclusive_lock_table.sv]
`timescale 1ns / 1ps
// Shared/exclusive lock table: keyed lookup, lock update and response register.
// Depends on selt_pkg.

// The table holds up to ENTRIES block keys, each with a lock value (-1 for an
// exclusive holder, 1..MAX_SHARED for shared holders). A request is captured in
// an input register; one pass of logic then compares its key against every
// entry and decides the outcome, and when the response register is free or
// being taken it writes the entry back and loads the response register. One
// request is accepted every cycle while responses drain; the rate is set by the
// parallel key compare and write-back. A conflict is answered at once and
// leaves the table unchanged. Entry valid bits clear on reset, so the table is
// usable on the first cycle after reset.

module shared_exclusive_lock_table #(
   parameter int ENTRIES    = 16,
   parameter int MAX_SHARED = 255
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [selt_pkg::CMD_W-1:0]           req_command,
   input  logic [selt_pkg::KEY_W-1:0]           req_block_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [selt_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [selt_pkg::VALUE_W-1:0]  rsp_lock_value
);
   import selt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic signed [VALUE_W-1:0] MAX_VALUE = VALUE_W'(MAX_SHARED);

   logic                        req_valid_ff, req_valid_in;
   cmd_type                     req_cmd_ff;
   logic [KEY_W-1:0]            req_key_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff;
   logic signed [VALUE_W-1:0]   rsp_value_ff;

   logic [ENTRIES-1:0]          entry_valid_ff, entry_valid_in;
   logic [KEY_W-1:0]            entry_key_ff   [ENTRIES];
   logic signed [VALUE_W-1:0]   entry_count_ff [ENTRIES];

   logic                        advance;
   logic                        found;
   logic [IDX_W-1:0]            found_idx;
   logic                        has_free;
   logic [IDX_W-1:0]            free_idx;
   logic signed [VALUE_W-1:0]   cur_count;
   logic                        is_excl;
   logic                        has_others;

   logic                        wr_en;
   logic [IDX_W-1:0]            wr_idx;
   logic signed [VALUE_W-1:0]   wr_count;
   logic                        set_valid;
   logic                        clr_valid;
   status_type                  status;
   logic signed [VALUE_W-1:0]   new_value;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_lock_value = rsp_value_ff;

   // lowest matching entry and lowest free entry
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      has_free  = 1'b0;
      free_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (entry_valid_ff[i] && entry_key_ff[i] == req_key_ff) begin
            found     = 1'b1;
            found_idx = IDX_W'(i);
         end
         if (!entry_valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign cur_count  = found ? entry_count_ff[found_idx] : LOCK_FREE;
   assign is_excl    = found && cur_count == LOCK_EXCL;
   assign has_others = found && !is_excl && cur_count > LOCK_ONE;

   always_comb begin
      status    = ST_GRANTED;
      new_value = cur_count;
      wr_en     = 1'b0;
      wr_idx    = found_idx;
      wr_count  = cur_count;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      case (req_cmd_ff)
         CMD_SHARED: begin
            if (is_excl) begin
               status = ST_XHELD;
            end else if (!found) begin
               if (!has_free) begin
                  status = ST_FULL;
               end else begin
                  wr_en     = 1'b1;
                  set_valid = 1'b1;
                  wr_idx    = free_idx;
                  wr_count  = LOCK_ONE;
                  new_value = LOCK_ONE;
               end
            end else if (cur_count >= MAX_VALUE) begin
               status = ST_FULL;
            end else begin
               wr_en     = 1'b1;
               wr_count  = cur_count + LOCK_ONE;
               new_value = cur_count + LOCK_ONE;
            end
         end
         CMD_EXCL: begin
            if (has_others) begin
               status = ST_OTHERS;
            end else if (!found) begin
               if (!has_free) begin
                  status = ST_FULL;
               end else begin
                  wr_en     = 1'b1;
                  set_valid = 1'b1;
                  wr_idx    = free_idx;
                  wr_count  = LOCK_EXCL;
                  new_value = LOCK_EXCL;
               end
            end else begin
               wr_en     = 1'b1;
               wr_count  = LOCK_EXCL;
               new_value = LOCK_EXCL;
            end
         end
         CMD_UNLOCK: begin
            if (!found) begin
               status    = ST_NOTHELD;
               new_value = LOCK_FREE;
            end else if (has_others) begin
               wr_en     = 1'b1;
               wr_count  = cur_count - LOCK_ONE;
               new_value = cur_count - LOCK_ONE;
            end else begin
               clr_valid = 1'b1;
               new_value = LOCK_FREE;
            end
         end
         CMD_UPGRADE: begin
            if (!found || is_excl) begin
               status = ST_NOSHARED;
            end else if (has_others) begin
               status = ST_OTHERS;
            end else begin
               wr_en     = 1'b1;
               wr_count  = LOCK_EXCL;
               new_value = LOCK_EXCL;
            end
         end
         default: begin
            status    = ST_GRANTED;
            new_value = cur_count;
         end
      endcase
   end

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (advance && set_valid) begin
         entry_valid_in[wr_idx] = 1'b1;
      end
      if (advance && clr_valid) begin
         entry_valid_in[found_idx] = 1'b0;
      end
   end

   assign req_valid_in = req_ready ? req_valid : req_valid_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         req_valid_ff   <= req_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_cmd_ff <= cmd_type'(req_command);
         req_key_ff <= req_block_key;
      end
      if (advance) begin
         rsp_status_ff <= status;
         rsp_value_ff  <= new_value;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && wr_en) begin
         entry_count_ff[wr_idx] <= wr_count;
         if (set_valid) begin
            entry_key_ff[wr_idx] <= req_key_ff;
         end
      end
   end

   a_occupancy_step: assert property (@(posedge clock) disable iff (reset)
      !reset |=> $countones(entry_valid_ff) <= $countones($past(entry_valid_ff)) + 1)
      else $error("lock table gained more than one entry in a cycle");

   a_full_means_no_free: assert property (@(posedge clock) disable iff (reset)
      advance && status == ST_FULL && !found |-> &entry_valid_ff)
      else $error("table full reported with a free entry");

   a_notheld_value: assert property (@(posedge clock) disable iff (reset)
      advance && req_cmd_ff == CMD_UNLOCK && !found
      |=> rsp_valid_ff && rsp_status_ff == ST_NOTHELD && rsp_value_ff == LOCK_FREE)
      else $error("unlock of absent key not answered as not held");

endmodule

[bench/lock_table_checker.sv]
`timescale 1ns / 1ps
// Checker for the shared/exclusive lock table: tracks accepted requests, predicts
// each answer from its own copy of the table and compares every response.
// Depends on selt_pkg.

module lock_table_checker #(
   parameter int ENTRIES    = 16,
   parameter int MAX_SHARED = 255
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [selt_pkg::CMD_W-1:0]           req_command,
   input  logic [selt_pkg::KEY_W-1:0]           req_block_key,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [selt_pkg::STATUS_W-1:0]        rsp_status,
   input  logic signed [selt_pkg::VALUE_W-1:0]  rsp_lock_value,
   output int                                   mismatches,
   output int                                   outstanding
);
   import selt_pkg::*;

   typedef struct {
      status_type                 status;
      logic signed [VALUE_W-1:0]  value;
   } answer_type;

   bit                         held     [ENTRIES];
   logic [KEY_W-1:0]           held_key [ENTRIES];
   logic signed [VALUE_W-1:0]  held_val [ENTRIES];
   answer_type                 answers  [$];

   task automatic resolve_lock(input cmd_type cmd, input logic [KEY_W-1:0] key,
                               output answer_type ans);
      int                         hit;
      int                         spare;
      logic signed [VALUE_W-1:0]  cur;
      hit   = -1;
      spare = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && held[i] && held_key[i] == key) hit = i;
         if (spare < 0 && !held[i]) spare = i;
      end
      cur = (hit >= 0) ? held_val[hit] : LOCK_FREE;
      ans.status = ST_GRANTED;
      ans.value  = cur;
      case (cmd)
         CMD_SHARED: begin
            if (cur < 0) begin
               ans.status = ST_XHELD;
            end else if (cur == 0) begin
               if (spare < 0) begin
                  ans.status = ST_FULL;
               end else begin
                  held[spare]     = 1'b1;
                  held_key[spare] = key;
                  held_val[spare] = LOCK_ONE;
                  ans.value       = LOCK_ONE;
               end
            end else if (cur >= MAX_SHARED) begin
               ans.status = ST_FULL;
            end else begin
               held_val[hit] = cur + LOCK_ONE;
               ans.value     = cur + LOCK_ONE;
            end
         end
         CMD_EXCL: begin
            if (cur > 1) begin
               ans.status = ST_OTHERS;
            end else if (cur == 0) begin
               if (spare < 0) begin
                  ans.status = ST_FULL;
               end else begin
                  held[spare]     = 1'b1;
                  held_key[spare] = key;
                  held_val[spare] = LOCK_EXCL;
                  ans.value       = LOCK_EXCL;
               end
            end else begin
               held_val[hit] = LOCK_EXCL;
               ans.value     = LOCK_EXCL;
            end
         end
         CMD_UNLOCK: begin
            if (hit < 0) begin
               ans.status = ST_NOTHELD;
               ans.value  = LOCK_FREE;
            end else if (cur > 1) begin
               held_val[hit] = cur - LOCK_ONE;
               ans.value     = cur - LOCK_ONE;
            end else begin
               held[hit] = 1'b0;
               ans.value = LOCK_FREE;
            end
         end
         default: begin
            if (cur <= 0) begin
               ans.status = ST_NOSHARED;
            end else if (cur > 1) begin
               ans.status = ST_OTHERS;
            end else begin
               held_val[hit] = LOCK_EXCL;
               ans.value     = LOCK_EXCL;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      answer_type fresh;
      answer_type oldest;
      if (reset) begin
         foreach (held[i]) held[i] = 1'b0;
         answers.delete();
      end else begin
         if (req_valid && req_ready) begin
            resolve_lock(cmd_type'(req_command), req_block_key, fresh);
            answers.push_back(fresh);
         end
         if (rsp_valid && rsp_ready) begin
            if (answers.size() == 0) begin
               $display("%0t lock table: response with no request waiting, %s %0d %0d",
                        $time, "status and value", rsp_status, rsp_lock_value);
               mismatches = mismatches + 1;
            end else begin
               oldest = answers.pop_front();
               if (rsp_status !== oldest.status) begin
                  $display("%0t lock table: status expected %0d got %0d",
                           $time, oldest.status, rsp_status);
                  mismatches = mismatches + 1;
               end
               if (rsp_lock_value !== oldest.value) begin
                  $display("%0t lock table: lock value expected %0d got %0d",
                           $time, oldest.value, rsp_lock_value);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
      outstanding = answers.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Top of the lock table bench: clock, reset, request stimulus, response stalls
// and the verdict. Depends on selt_pkg, shared_exclusive_lock_table, lock_table_checker.

module tb;
   import selt_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int MAX_SHARED = 255;
   localparam int POOL       = 20;
   localparam int LIMIT      = 200000;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_command    = CMD_SHARED;
   logic [KEY_W-1:0]           req_block_key  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [VALUE_W-1:0]  rsp_lock_value;

   int                         mismatches;
   int                         outstanding;
   int                         cycle_count    = 0;
   int                         issued         = 0;
   int                         send_idle_pct  = 0;
   int                         stall_pct      = 0;
   bit                         hold_arm       = 1'b0;
   bit                         hold_taken     = 1'b0;
   int                         hold_left      = 0;
   logic [KEY_W-1:0]           keys [POOL];

   shared_exclusive_lock_table #(
      .ENTRIES    (ENTRIES),
      .MAX_SHARED (MAX_SHARED)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_block_key  (req_block_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_lock_value (rsp_lock_value)
   );

   lock_table_checker #(
      .ENTRIES    (ENTRIES),
      .MAX_SHARED (MAX_SHARED)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_block_key  (req_block_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_lock_value (rsp_lock_value),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // stall responses at random; hold off once for a long stretch when armed
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= 120;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [KEY_W-1:0] any_key();
      return KEY_W'({$urandom, $urandom});
   endfunction

   task automatic send_request(input cmd_type cmd, input logic [KEY_W-1:0] key);
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_block_key <= key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      issued++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic directed_requests();
      logic [KEY_W-1:0] ones;
      logic [KEY_W-1:0] zero;
      ones = '1;
      zero = '0;
      send_request(CMD_SHARED, zero);
      send_request(CMD_SHARED, ones);
      send_request(CMD_EXCL, ones);
      send_request(CMD_SHARED, ones);
      send_request(CMD_UPGRADE, ones);
      send_request(CMD_EXCL, ones);
      send_request(CMD_UNLOCK, ones);
      send_request(CMD_UNLOCK, ones);
      send_request(CMD_UPGRADE, ones);
      send_request(CMD_SHARED, zero);
      send_request(CMD_EXCL, zero);
      send_request(CMD_UPGRADE, zero);
      send_request(CMD_UNLOCK, zero);
      send_request(CMD_UPGRADE, zero);
      send_request(CMD_UNLOCK, zero);
      send_request(CMD_EXCL, {KEY_W/2{2'b01}});
      send_request(CMD_UNLOCK, {KEY_W/2{2'b01}});
      send_request(CMD_SHARED, {KEY_W/2{2'b10}});
      send_request(CMD_UNLOCK, {KEY_W/2{2'b10}});
   endtask

   // drive one key to its shared limit and past it, then back off a little
   task automatic saturate_shared();
      logic [KEY_W-1:0] key;
      key = any_key();
      repeat (MAX_SHARED + 1) send_request(CMD_SHARED, key);
      send_request(CMD_EXCL, key);
      send_request(CMD_UPGRADE, key);
      repeat (3) send_request(CMD_UNLOCK, key);
   endtask

   // lock more fresh keys than the table holds, then release them
   task automatic overfill_table();
      logic [KEY_W-1:0] fresh [ENTRIES+1];
      foreach (fresh[i]) begin
         fresh[i] = any_key();
         send_request(cmd_type'((i % 2) ? CMD_EXCL : CMD_SHARED), fresh[i]);
      end
      send_request(CMD_SHARED, fresh[ENTRIES]);
      foreach (fresh[i]) send_request(CMD_UNLOCK, fresh[i]);
   endtask

   task automatic random_traffic(input int count);
      int               target;
      int               pick;
      int               weight;
      logic [KEY_W-1:0] key;
      target = issued + count;
      while (issued < target) begin
         key  = keys[$urandom_range(POOL-1)];
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_request(cmd_type'($urandom_range(3)), any_key());
         end else if (pick < 40) begin
            case ($urandom_range(2))
               0: begin
                  send_request(CMD_SHARED, key);
                  send_request(CMD_UPGRADE, key);
                  send_request(CMD_UNLOCK, key);
               end
               1: begin
                  send_request(CMD_EXCL, key);
                  send_request(CMD_UNLOCK, key);
               end
               default: begin
                  send_request(CMD_SHARED, key);
                  send_request(CMD_SHARED, key);
                  send_request(CMD_UNLOCK, key);
                  send_request(CMD_UNLOCK, key);
               end
            endcase
         end else begin
            weight = $urandom_range(99);
            if (weight < 35)      send_request(CMD_SHARED, key);
            else if (weight < 55) send_request(CMD_EXCL, key);
            else if (weight < 85) send_request(CMD_UNLOCK, key);
            else                  send_request(CMD_UPGRADE, key);
         end
      end
   endtask

   initial begin
      keys[0] = '0;
      keys[1] = '1;
      for (int i = 2; i < POOL; i++) keys[i] = any_key();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      directed_requests();

      hold_arm = 1'b1;
      saturate_shared();
      random_traffic(60);

      send_idle_pct = 81;
      random_traffic(60);

      send_idle_pct = 0;
      stall_pct     = 81;
      overfill_table();
      random_traffic(60);

      send_idle_pct = 6;
      stall_pct     = 6;
      random_traffic(60);

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
